@@ sv/ostk_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ostk_pkg
// Types and codes shared by the operand stack controller, datapath and top.
// ---------------------------------------------------------------------------
package ostk_pkg;

   // Command codes carried in the action field
   localparam logic [2:0] ACT_PUSH   = 3'd0;
   localparam logic [2:0] ACT_POP    = 3'd1;
   localparam logic [2:0] ACT_DROP   = 3'd2;
   localparam logic [2:0] ACT_SWAP   = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;
   localparam logic [2:0] ACT_ROLL_L = 3'd5;
   localparam logic [2:0] ACT_ROLL_R = 3'd6;

   // Result status codes
   localparam logic [1:0] RSP_OK    = 2'd0;
   localparam logic [1:0] RSP_UNDER = 2'd1;
   localparam logic [1:0] RSP_OVER  = 2'd2;

   localparam int WORD_W  = 64;
   localparam int COUNT_W = 7;

   // Input transaction payload
   typedef struct packed {
      logic [2:0]        action;
      logic [WORD_W-1:0] push_value;
   } req_type;

   // Result transaction payload
   typedef struct packed {
      logic [WORD_W-1:0]  popped_value;
      logic [1:0]         status;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       latch;
      logic       push_wr;
      logic       pop_rd;
      logic       clear;
      logic       walk_start;
      logic       walk_step;
      logic       walk_final;
      logic       load_rsp;
      logic       pop_sel;
      logic [1:0] rsp_status;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [2:0] action;
      logic       empty;
      logic       full;
      logic       below_two;
      logic       walk_last;
      logic       rsp_free;
   } stat_type;

endpackage

@@ sv/ostk_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ostk_ram
// Generic simple dual-port RAM: one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ostk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; holds its value between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ostk_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ostk_ctrl
// Sequencer of the operand stack: dispatches one command at a time and
// steps the datapath through reads, walks and the result hand-off.
// ---------------------------------------------------------------------------
module ostk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ostk_pkg::stat_type stat,
   output ostk_pkg::cmd_type  cmd
);
   import ostk_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_POPWAIT,
      S_WALK,
      S_DRAIN,
      S_FINAL,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       sel_ff, sel_in;

   logic       finish;
   logic [1:0] fin_code;
   logic       fin_sel;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      finish   = 1'b0;
      fin_code = RSP_OK;
      fin_sel  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.action)
               ACT_PUSH: begin
                  if (stat.full) begin
                     fin_code = RSP_OVER;
                  end else begin
                     cmd.push_wr = 1'b1;
                  end
                  finish = 1'b1;
               end
               ACT_POP, ACT_DROP: begin
                  if (stat.empty) begin
                     fin_code = RSP_UNDER;
                     finish   = 1'b1;
                  end else begin
                     cmd.pop_rd = 1'b1;
                     state_in   = S_POPWAIT;
                  end
               end
               ACT_SWAP: begin
                  if (stat.below_two) begin
                     finish = 1'b1;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               ACT_CLEAR: begin
                  cmd.clear = 1'b1;
                  finish    = 1'b1;
               end
               ACT_ROLL_L, ACT_ROLL_R: begin
                  if (stat.empty) begin
                     finish = 1'b1;
                  end else begin
                     cmd.walk_start = 1'b1;
                     state_in       = S_WALK;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         S_POPWAIT: begin
            fin_sel = 1'b1;
            finish  = 1'b1;
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (stat.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FINAL;
         end
         S_FINAL: begin
            cmd.walk_final = 1'b1;
            finish         = 1'b1;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp   = 1'b1;
               cmd.rsp_status = code_ff;
               cmd.pop_sel    = sel_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Hand the result over now, or park it until the output is free
      if (finish) begin
         if (stat.rsp_free) begin
            cmd.load_rsp   = 1'b1;
            cmd.rsp_status = fin_code;
            cmd.pop_sel    = fin_sel;
            state_in       = S_IDLE;
         end else begin
            code_in  = fin_code;
            sel_in   = fin_sel;
            state_in = S_DONE;
         end
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= RSP_OK;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         sel_ff   <= sel_in;
      end
   end

   // Checks
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DISPATCH))
      else $error("accepted transaction not dispatched");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !stat.rsp_free) |=> (state_ff == S_DONE))
      else $error("parked result dropped");

   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |=> (state_ff == S_FINAL))
      else $error("walk did not close with the final write");

endmodule

@@ sv/ostk_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ostk_dp
// Operand stack datapath: entry store, entry count, walk address counter
// and the result register.
// ---------------------------------------------------------------------------
module ostk_dp #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ostk_pkg::req_type  req_data,
   input  ostk_pkg::cmd_type  cmd,
   output ostk_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ostk_pkg::rsp_type  rsp_data
);
   import ostk_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Latched command
   logic [2:0]        act_ff;
   logic [WORD_W-1:0] val_ff;

   // Entry count
   logic [CW-1:0]     sp_ff, sp_in;
   logic [CW-1:0]     sp_m1, sp_m2;
   logic [AW-1:0]     top_idx, sec_idx;

   // Walk state
   logic [AW-1:0]     addr_ff, end_ff, pend_addr_ff;
   logic              up_ff, first_ff, pend_ff, pend_first_ff;
   logic [WORD_W-1:0] t_ff;

   // Result register
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   // RAM ports
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [WORD_W-1:0] wr_data, rd_data;

   assign sp_m1   = sp_ff - CW'(1);
   assign sp_m2   = sp_ff - CW'(2);
   assign top_idx = sp_m1[AW-1:0];
   assign sec_idx = sp_m2[AW-1:0];

   // Status to the controller
   assign stat.action    = act_ff;
   assign stat.empty     = (sp_ff == '0);
   assign stat.full      = (sp_ff == CW'(DEPTH));
   assign stat.below_two = (sp_ff < CW'(2));
   assign stat.walk_last = (addr_ff == end_ff);
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Next entry count
   always_comb begin
      sp_in = sp_ff;
      if (cmd.clear) begin
         sp_in = '0;
      end else if (cmd.push_wr) begin
         sp_in = sp_ff + CW'(1);
      end else if (cmd.pop_rd) begin
         sp_in = sp_m1;
      end
   end

   // Write port: push, walk shift, then the saved end word
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sp_ff[AW-1:0];
      wr_data = val_ff;
      if (cmd.push_wr) begin
         wr_en = 1'b1;
      end else if (cmd.walk_final) begin
         wr_en   = 1'b1;
         wr_addr = end_ff;
         wr_data = t_ff;
      end else if (pend_ff && !pend_first_ff) begin
         wr_en   = 1'b1;
         wr_addr = up_ff ? (pend_addr_ff - AW'(1)) : (pend_addr_ff + AW'(1));
         wr_data = rd_data;
      end
   end

   // Read port: pop or walk
   assign rd_en   = cmd.pop_rd || cmd.walk_step;
   assign rd_addr = cmd.pop_rd ? top_idx : addr_ff;

   ostk_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff   <= sp_in;
         pend_ff <= cmd.walk_step;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff <= req_data.action;
         val_ff <= req_data.push_value;
      end
      // Walk set-up: roll left climbs, roll right and swap descend
      if (cmd.walk_start) begin
         first_ff <= 1'b1;
         case (act_ff)
            ACT_ROLL_L: begin
               addr_ff <= '0;
               end_ff  <= top_idx;
               up_ff   <= 1'b1;
            end
            ACT_ROLL_R: begin
               addr_ff <= top_idx;
               end_ff  <= '0;
               up_ff   <= 1'b0;
            end
            default: begin
               addr_ff <= top_idx;
               end_ff  <= sec_idx;
               up_ff   <= 1'b0;
            end
         endcase
      end else if (cmd.walk_step) begin
         addr_ff       <= up_ff ? (addr_ff + AW'(1)) : (addr_ff - AW'(1));
         first_ff      <= 1'b0;
         pend_addr_ff  <= addr_ff;
         pend_first_ff <= first_ff;
      end
      // First word read in a walk is kept for the far end
      if (pend_ff && pend_first_ff) begin
         t_ff <= rd_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff.popped_value <= cmd.pop_sel ? rd_data : '0;
         rsp_ff.status       <= cmd.rsp_status;
         rsp_ff.entry_count  <= COUNT_W'(sp_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a waiting transaction");

   a_walk_ports: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step && wr_en) |-> (wr_addr != rd_addr))
      else $error("walk writes the entry it reads");

endmodule

@@ sv/operand_stack_with_roll_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// operand_stack_with_roll_unit
// Bounded stack of 64-bit operands with push, pop, drop, swap, clear, roll.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one command per transaction (action, push_value); every
//   command returns exactly one transaction on rsp_* (popped_value, status,
//   entry_count). Both channels move a transaction when valid is high and
//   stall is low.
//   Accept to result register load, when that register is free: push,
//   clear, swaps on fewer than two entries, rolls on an empty stack and
//   failed pops end in dispatch; pop and drop add a pop-wait state; swap
//   and roll walk the entries, reading and rewriting one entry per cycle
//   through the single write port of the entry store, then drain and write
//   the saved end word. The next command is taken in the cycle after the load.
//   One command is in flight at a time; req_stall is high while it works.
//   The result register is separate, so a new command is taken while a
//   result still waits; a stalled receiver holds the next result back in
//   the sequencer until the register frees.
//   Reset (synchronous) empties the stack and drops any pending result;
//   the entry store itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
module operand_stack_with_roll_unit #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ostk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ostk_pkg::rsp_type rsp_data
);
   import ostk_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ostk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ostk_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ tb/operand_stack_with_roll_unit_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// operand_stack_with_roll_unit_test
// Self-checking bench for the 64-bit operand stack with roll commands.
// A short table of hand-picked commands (empty and single-entry corners, all
// eight action codes, the word extremes) is followed by random phases that
// fill the stack to overflow, drain it to underflow, mix every command and
// roll deep stacks. Each accepted command goes through a local stack model.
// Every result is compared field by field, in order, with that model's
// prediction or a table row's literal result. Both channels idle at random.
// ---------------------------------------------------------------------------
module operand_stack_with_roll_unit_test;
   import ostk_pkg::*;

   localparam int STACK_DEPTH  = 64;
   localparam int RANDOM_ITEMS = 1950;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_CYCLES = STACK_DEPTH + 20;
   localparam int N_DIRECTED   = 25;

   // Unused action code: the block treats it as a no-op
   localparam logic [2:0] ACT_NONE = 3'd7;
   localparam logic [63:0] WORD_ONES = {64{1'b1}};

   // Random phase kinds
   typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_ROLL} phase_type;

   // One row of the directed table: command plus an optional literal result
   typedef struct packed {
      logic [2:0]  action;
      logic [63:0] push_value;
      logic        literal;
      rsp_type     want;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Local copy of the stack
   logic [63:0] stack_words [STACK_DEPTH];
   int          stack_fill;

   rsp_type due_stack_results [$];
   rsp_type head_result;

   int cycle_count;
   int error_count;
   int commands_sent;
   int results_seen;
   int overflow_hits;
   int underflow_hits;
   int full_rolls;
   int stall_mode;
   int stall_left;

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{ACT_POP,    64'd0,     1'b1, '{64'd0, RSP_UNDER, 7'd0}},
      '{ACT_DROP,   WORD_ONES, 1'b1, '{64'd0, RSP_UNDER, 7'd0}},
      '{ACT_SWAP,   64'd0,     1'b1, '{64'd0, RSP_OK, 7'd0}},
      '{ACT_ROLL_L, 64'd0,     1'b1, '{64'd0, RSP_OK, 7'd0}},
      '{ACT_ROLL_R, WORD_ONES, 1'b1, '{64'd0, RSP_OK, 7'd0}},
      '{ACT_NONE,   WORD_ONES, 1'b1, '{64'd0, RSP_OK, 7'd0}},
      '{ACT_CLEAR,  64'd0,     1'b1, '{64'd0, RSP_OK, 7'd0}},
      '{ACT_PUSH,   WORD_ONES, 1'b1, '{64'd0, RSP_OK, 7'd1}},
      '{ACT_SWAP,   64'd0,     1'b1, '{64'd0, RSP_OK, 7'd1}},
      '{ACT_ROLL_L, 64'd0,     1'b1, '{64'd0, RSP_OK, 7'd1}},
      '{ACT_ROLL_R, 64'd0,     1'b1, '{64'd0, RSP_OK, 7'd1}},
      '{ACT_POP,    64'd0,     1'b1, '{WORD_ONES, RSP_OK, 7'd0}},
      '{ACT_PUSH,   64'd0,                   1'b0, '0},
      '{ACT_PUSH,   64'h8000_0000_0000_0001, 1'b0, '0},
      '{ACT_PUSH,   64'h0123_4567_89ab_cdef, 1'b0, '0},
      '{ACT_SWAP,   64'd0,                   1'b0, '0},
      '{ACT_ROLL_L, 64'd0,                   1'b0, '0},
      '{ACT_ROLL_R, WORD_ONES,               1'b0, '0},
      '{ACT_NONE,   64'h5a5a_5a5a_5a5a_5a5a, 1'b0, '0},
      '{ACT_DROP,   64'd0,                   1'b0, '0},
      '{ACT_POP,    64'd0,                   1'b0, '0},
      '{ACT_CLEAR,  64'd0,                   1'b0, '0},
      '{ACT_POP,    64'd0,     1'b1, '{64'd0, RSP_UNDER, 7'd0}},
      '{ACT_PUSH,   64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
      '{ACT_PUSH,   64'h5555_5555_5555_5555, 1'b0, '0}
   };

   operand_stack_with_roll_unit #(
      .DEPTH(STACK_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  due_stack_results.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Applies one command to the local stack and returns the result it gives
   function automatic rsp_type apply_stack_command(input req_type cmd);
      rsp_type     r;
      logic [63:0] held;
      int          i;
      r = '0;
      case (cmd.action)
         ACT_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               r.status = RSP_OVER;
               overflow_hits++;
            end else begin
               stack_words[stack_fill] = cmd.push_value;
               stack_fill++;
            end
         end
         ACT_POP, ACT_DROP: begin
            if (stack_fill == 0) begin
               r.status = RSP_UNDER;
               underflow_hits++;
            end else begin
               r.popped_value = stack_words[stack_fill - 1];
               stack_fill--;
            end
         end
         ACT_SWAP: begin
            if (stack_fill >= 2) begin
               held = stack_words[stack_fill - 1];
               stack_words[stack_fill - 1] = stack_words[stack_fill - 2];
               stack_words[stack_fill - 2] = held;
            end
         end
         ACT_CLEAR: begin
            stack_fill = 0;
         end
         // bottom entry goes to the top
         ACT_ROLL_L: begin
            if (stack_fill > 0) begin
               held = stack_words[0];
               for (i = 0; i + 1 < stack_fill; i++)
                  stack_words[i] = stack_words[i + 1];
               stack_words[stack_fill - 1] = held;
            end
            if (stack_fill == STACK_DEPTH)
               full_rolls++;
         end
         // top entry goes to the bottom
         ACT_ROLL_R: begin
            if (stack_fill > 0) begin
               held = stack_words[stack_fill - 1];
               for (i = stack_fill - 1; i > 0; i--)
                  stack_words[i] = stack_words[i - 1];
               stack_words[0] = held;
            end
            if (stack_fill == STACK_DEPTH)
               full_rolls++;
         end
         default: begin
         end
      endcase
      r.entry_count = 7'(stack_fill);
      return r;
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] bit_word;
      bit_word = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return WORD_ONES;
         2:       return bit_word;
         3:       return ~bit_word;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Action mix per phase; fill, drain and roll phases keep clear out
   function automatic logic [2:0] pick_action(input phase_type phase);
      int r;
      r = $urandom_range(0, 19);
      case (phase)
         PH_FILL: begin
            if (r < 16)       return ACT_PUSH;
            else if (r == 16) return ACT_SWAP;
            else if (r == 17) return ACT_ROLL_L;
            else if (r == 18) return ACT_ROLL_R;
            else              return ACT_POP;
         end
         PH_DRAIN: begin
            if (r < 8)        return ACT_POP;
            else if (r < 14)  return ACT_DROP;
            else if (r < 16)  return ACT_PUSH;
            else if (r == 16) return ACT_SWAP;
            else if (r == 17) return ACT_ROLL_R;
            else if (r == 18) return ACT_ROLL_L;
            else              return ACT_NONE;
         end
         PH_ROLL: begin
            if (r < 7)        return ACT_ROLL_L;
            else if (r < 14)  return ACT_ROLL_R;
            else if (r < 17)  return ACT_SWAP;
            else if (r < 19)  return ACT_PUSH;
            else              return ACT_POP;
         end
         default: return 3'($urandom_range(0, 7));
      endcase
   endfunction

   // Drives one transaction from a falling edge and holds it until taken
   task automatic send_command(input req_type cmd, input logic literal, input rsp_type want);
      rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = apply_stack_command(cmd);
      due_stack_results.push_back(literal ? want : predicted);
      commands_sent++;
      @(negedge clock);
   endtask

   // Holds the sender off until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (due_stack_results.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < 100)
         $display("cycle %0d: %0s mismatch, got %h expected %h", cycle_count, what, got,
                  want);
      error_count++;
   endtask

   // Receiver stall: switches at random among four patterns
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(50, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ((cycle_count % 7) < 3);
         default: rsp_stall <= ($urandom_range(0, 1) == 0);
      endcase
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (due_stack_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.popped_value, 64'd0);
         end else begin
            head_result = due_stack_results.pop_front();
            if (rsp_data.popped_value !== head_result.popped_value)
               report_mismatch("popped_value", rsp_data.popped_value,
                               head_result.popped_value);
            if (rsp_data.status !== head_result.status)
               report_mismatch("status", 64'(rsp_data.status), 64'(head_result.status));
            if (rsp_data.entry_count !== head_result.entry_count)
               report_mismatch("entry_count", 64'(rsp_data.entry_count),
                               64'(head_result.entry_count));
         end
      end
   end

   // Stimulus
   initial begin
      req_type   cmd;
      phase_type phase;
      int        phase_len;
      int        burst_left;
      int        n;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      stack_fill = 0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (n = 0; n < N_DIRECTED; n++) begin
         cmd.action     = directed_rows[n].action;
         cmd.push_value = directed_rows[n].push_value;
         send_command(cmd, directed_rows[n].literal, directed_rows[n].want);
      end
      wait_drained();

      // Random phases
      while (commands_sent < N_DIRECTED + RANDOM_ITEMS) begin
         phase = phase_type'($urandom_range(0, 3));
         case (phase)
            PH_FILL:  phase_len = $urandom_range(90, 130);
            PH_DRAIN: phase_len = $urandom_range(80, 120);
            PH_ROLL:  phase_len = $urandom_range(10, 40);
            default:  phase_len = $urandom_range(20, 60);
         endcase
         for (n = 0; n < phase_len; n++) begin
            // sender bursts; now and then a long burst with no gaps
            if (burst_left == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(negedge clock);
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(1, 24);
            end
            cmd.action     = pick_action(phase);
            cmd.push_value = random_word();
            send_command(cmd, 1'b0, '0);
            burst_left--;
         end
         if ($urandom_range(0, 3) == 0)
            wait_drained();
      end

      // Let the last results arrive, then watch for strays
      req_valid <= 1'b0;
      while (due_stack_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("ran %0d commands over %0d cycles, %0d results checked", commands_sent,
               cycle_count, results_seen);
      $display("hit %0d overflows, %0d underflows and %0d rolls of a full stack",
               overflow_hits, underflow_hits, full_rolls);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ operand_stack_with_roll_unit.f @@
sv/ostk_pkg.sv
sv/ostk_ram.sv
sv/ostk_ctrl.sv
sv/ostk_dp.sv
sv/operand_stack_with_roll_unit.sv
tb/operand_stack_with_roll_unit_test.sv
